// ===== sv/sssc_pkg.sv =====
// ----------------------------------------------------------------------------
// sssc_pkg
// Shared types and constants of the stepper speed and slew controller.
// ----------------------------------------------------------------------------
package sssc_pkg;

	localparam int ClkW     = 28;
	localparam int DivW     = 17;
	localparam int FreqW    = 16;
	localparam int ProdW    = FreqW + DivW;
	localparam int PeriodW  = 22;
	localparam int CompareW = 21;
	localparam int DivSteps = ClkW;
	localparam int DivCntW  = $clog2(DivSteps);
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = ClkW;
	localparam int ScaleShift = 7;

	localparam logic [ClkW-1:0]    RstClockHz   = ClkW'(80000000);
	localparam logic [DivW-1:0]    RstDivider   = DivW'(80);
	localparam logic [FreqW-1:0]   RstFullH     = FreqW'(20000);
	localparam logic [FreqW-1:0]   RstFullV     = FreqW'(500);
	localparam logic [FreqW-1:0]   RstJump      = FreqW'(2000);
	localparam logic [FreqW-1:0]   RstRamp      = FreqW'(600);
	localparam logic [FreqW-1:0]   RstRevThr    = FreqW'(1500);
	localparam logic [PeriodW-1:0] PeriodMax    = {PeriodW{1'b1}};
	localparam logic [FreqW-1:0]   FreqMax      = {FreqW{1'b1}};

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CLOCK_HZ   = 3'd0,
		CFG_DIVIDER    = 3'd1,
		CFG_FULL_H     = 3'd2,
		CFG_FULL_V     = 3'd3,
		CFG_JUMP_LIMIT = 3'd4,
		CFG_RAMP_STEP  = 3'd5,
		CFG_REV_THR    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [7:0] joy_x;
		logic signed [7:0] joy_y;
		logic              fire_request;
	} in_item_t;

	typedef struct packed {
		logic [PeriodW-1:0]  period_h;
		logic [CompareW-1:0] compare_h;
		logic                run_h;
		logic                dir_h_out;
		logic [PeriodW-1:0]  period_v;
		logic [CompareW-1:0] compare_v;
		logic                run_v;
		logic                dir_v_out;
		logic                fire_pulse;
	} out_item_t;

	typedef struct packed {
		logic cap;
		logic scale;
		logic slew;
		logic mult;
		logic div_step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
	} ctrl_status_t;

	typedef struct packed {
		logic [ClkW:0]   rem;
		logic [ClkW-1:0] quo;
	} div_lane_t;

endpackage

// ===== sv/sssc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sssc_ctrl
// Sequencer: scale, slew, multiply, divide, then load the result register.
// ----------------------------------------------------------------------------
module sssc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  sssc_pkg::ctrl_status_t status,
	output sssc_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCALE,
		S_SLEW,
		S_MULT,
		S_DIV,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_load;

	// result register is free, or its transaction completes this cycle
	assign can_load = !out_valid_q || !out_stall;

	always_comb begin
		cmd          = '0;
		cmd.cap      = (state_q == S_IDLE) && in_valid;
		cmd.scale    = (state_q == S_SCALE);
		cmd.slew     = (state_q == S_SLEW);
		cmd.mult     = (state_q == S_MULT);
		cmd.div_step = (state_q == S_DIV);
		cmd.out_load = (state_q == S_FINISH) && can_load;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: state_q <= S_SLEW;
				S_SLEW:  state_q <= S_MULT;
				S_MULT:  state_q <= S_DIV;
				S_DIV: begin
					if (status.div_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> (state_q == S_SCALE))
		else $error("accepted transaction did not start scaling");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && status.div_done) |=> (state_q == S_FINISH))
		else $error("divider finished but sequencer did not move on");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && can_load) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result not presented after finish");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FINISH))
		else $error("result valid raised outside finish");
`endif

endmodule

// ===== sv/sssc_dpath.sv =====
// ----------------------------------------------------------------------------
// sssc_dpath
// Settings registers, axis state, scaling, slew limit, two divider lanes and
// the result register.
// ----------------------------------------------------------------------------
module sssc_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sssc_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [sssc_pkg::CfgDataW-1:0]       cfg_data,
	input  sssc_pkg::in_item_t                  in_data,
	input  sssc_pkg::ctrl_cmd_t                 cmd,
	output sssc_pkg::ctrl_status_t              status,
	output sssc_pkg::out_item_t                 out_data
);

	localparam int FW = sssc_pkg::FreqW;

	// settings
	logic [sssc_pkg::ClkW-1:0] clock_hz_q;
	logic [sssc_pkg::DivW-1:0] divider_q;
	logic [FW-1:0]             full_h_q;
	logic [FW-1:0]             full_v_q;
	logic [FW-1:0]             jump_q;
	logic [FW-1:0]             ramp_q;
	logic [FW-1:0]             rev_thr_q;

	// axis state
	logic          dir_v_q;
	logic          dir_h_q;
	logic          rev_pend_q;
	logic [FW-1:0] last_freq_q;

	// working registers
	sssc_pkg::in_item_t         in_q;
	logic [FW-1:0]              fh_raw_q;
	logic [FW-1:0]              fh_q;
	logic [FW-1:0]              fv_q;
	logic [sssc_pkg::ProdW-1:0] prod_h_q;
	logic [sssc_pkg::ProdW-1:0] prod_v_q;
	sssc_pkg::div_lane_t        lane_h_q;
	sssc_pkg::div_lane_t        lane_v_q;
	logic [sssc_pkg::DivCntW-1:0] cnt_q;
	sssc_pkg::out_item_t        out_q;

	logic                       xneg, xpos, yneg, ypos;
	logic [7:0]                 ax, ay;
	logic [FW+7:0]              mul_h, mul_v;
	logic [sssc_pkg::DivW-1:0]  div_eff;
	logic                       dir_v_nxt, dir_h_nxt, rev_nxt;
	logic [FW-1:0]              fh_nxt;
	logic [FW:0]                sum_fl, last_plus_jump, last_plus_ramp;
	logic [FW:0]                last_minus_ramp;
	logic [FW-1:0]              last_minus_jump;
	logic [sssc_pkg::PeriodW-1:0] per_h, per_v;

	function automatic sssc_pkg::div_lane_t lane_step(sssc_pkg::div_lane_t s,
		logic [sssc_pkg::ProdW-1:0] d);
		sssc_pkg::div_lane_t        r;
		logic [sssc_pkg::ClkW:0]    trial;
		logic                       ge;
		trial = {s.rem[sssc_pkg::ClkW-1:0], s.quo[sssc_pkg::ClkW-1]};
		ge    = {{(sssc_pkg::ProdW-sssc_pkg::ClkW-1){1'b0}}, trial} >= d;
		r.rem = ge ? (trial - d[sssc_pkg::ClkW:0]) : trial;
		r.quo = {s.quo[sssc_pkg::ClkW-2:0], ge};
		return r;
	endfunction

	function automatic logic [sssc_pkg::PeriodW-1:0] to_period(
		logic [sssc_pkg::ClkW-1:0] q);
		logic [sssc_pkg::ClkW-1:0] p;
		p = (q == '0) ? '0 : q - 1'b1;
		if (p > {{(sssc_pkg::ClkW-sssc_pkg::PeriodW){1'b0}}, sssc_pkg::PeriodMax}) begin
			return sssc_pkg::PeriodMax;
		end
		return p[sssc_pkg::PeriodW-1:0];
	endfunction

	// sign and magnitude of the deflections
	always_comb begin
		xneg = in_q.joy_x[7];
		yneg = in_q.joy_y[7];
		xpos = !xneg && (in_q.joy_x != '0);
		ypos = !yneg && (in_q.joy_y != '0);
		ax   = xneg ? 8'(-in_q.joy_x) : 8'(in_q.joy_x);
		ay   = yneg ? 8'(-in_q.joy_y) : 8'(in_q.joy_y);
		mul_h = (FW+8)'(ax) * (FW+8)'(full_h_q);
		mul_v = (FW+8)'(ay) * (FW+8)'(full_v_q);
	end

	// direction state and horizontal slew limit
	always_comb begin
		dir_v_nxt = dir_v_q;
		if (yneg) begin
			dir_v_nxt = 1'b0;
		end else if (ypos) begin
			dir_v_nxt = 1'b1;
		end
		rev_nxt   = rev_pend_q || (dir_h_q && xneg) || (!dir_h_q && xpos);
		dir_h_nxt = dir_h_q;

		sum_fl          = {1'b0, fh_raw_q} + {1'b0, last_freq_q};
		last_plus_jump  = {1'b0, last_freq_q} + {1'b0, jump_q};
		last_plus_ramp  = {1'b0, last_freq_q} + {1'b0, ramp_q};
		last_minus_ramp = {1'b0, last_freq_q} - {1'b0, ramp_q};
		last_minus_jump = last_freq_q - jump_q;
		fh_nxt          = fh_raw_q;

		if (rev_nxt) begin
			if (sum_fl >= {1'b0, rev_thr_q}) begin
				if (last_freq_q < ramp_q) begin
					dir_h_nxt = !dir_h_q;
					rev_nxt   = 1'b0;
					fh_nxt    = ramp_q - last_freq_q;
				end else begin
					fh_nxt = last_minus_ramp[FW-1:0];
				end
			end else begin
				dir_h_nxt = !dir_h_q;
				rev_nxt   = 1'b0;
			end
		end else if ({1'b0, fh_raw_q} >= last_plus_jump) begin
			fh_nxt = last_plus_ramp[FW] ? sssc_pkg::FreqMax : last_plus_ramp[FW-1:0];
		end else if (last_freq_q >= jump_q && fh_raw_q <= last_minus_jump) begin
			// a ramp below zero wraps high and saturates
			fh_nxt = last_minus_ramp[FW] ? sssc_pkg::FreqMax : last_minus_ramp[FW-1:0];
		end
	end

	assign div_eff         = (divider_q == '0) ? sssc_pkg::DivW'(1) : divider_q;
	assign status.div_done = (cnt_q == sssc_pkg::DivCntW'(sssc_pkg::DivSteps - 1));
	assign out_data        = out_q;
	assign per_h           = to_period(lane_h_q.quo);
	assign per_v           = to_period(lane_v_q.quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q  <= sssc_pkg::RstClockHz;
			divider_q   <= sssc_pkg::RstDivider;
			full_h_q    <= sssc_pkg::RstFullH;
			full_v_q    <= sssc_pkg::RstFullV;
			jump_q      <= sssc_pkg::RstJump;
			ramp_q      <= sssc_pkg::RstRamp;
			rev_thr_q   <= sssc_pkg::RstRevThr;
			dir_v_q     <= 1'b0;
			dir_h_q     <= 1'b0;
			rev_pend_q  <= 1'b0;
			last_freq_q <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (sssc_pkg::cfg_reg_t'(cfg_index))
					sssc_pkg::CFG_CLOCK_HZ:   clock_hz_q <= cfg_data;
					sssc_pkg::CFG_DIVIDER:    divider_q  <= cfg_data[sssc_pkg::DivW-1:0];
					sssc_pkg::CFG_FULL_H:     full_h_q   <= cfg_data[FW-1:0];
					sssc_pkg::CFG_FULL_V:     full_v_q   <= cfg_data[FW-1:0];
					sssc_pkg::CFG_JUMP_LIMIT: jump_q     <= cfg_data[FW-1:0];
					sssc_pkg::CFG_RAMP_STEP:  ramp_q     <= cfg_data[FW-1:0];
					sssc_pkg::CFG_REV_THR:    rev_thr_q  <= cfg_data[FW-1:0];
					default: ;
				endcase
			end
			if (cmd.slew) begin
				dir_v_q     <= dir_v_nxt;
				dir_h_q     <= dir_h_nxt;
				rev_pend_q  <= rev_nxt;
				last_freq_q <= fh_nxt;
			end
			if (cmd.mult) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			in_q <= in_data;
		end
		if (cmd.scale) begin
			// deflection times full scale over 128, never above 16 bits
			fh_raw_q <= mul_h[FW+sssc_pkg::ScaleShift-1:sssc_pkg::ScaleShift];
			fv_q     <= mul_v[FW+sssc_pkg::ScaleShift-1:sssc_pkg::ScaleShift];
		end
		if (cmd.slew) begin
			fh_q <= fh_nxt;
		end
		if (cmd.mult) begin
			prod_h_q     <= sssc_pkg::ProdW'(fh_q) * sssc_pkg::ProdW'(div_eff);
			prod_v_q     <= sssc_pkg::ProdW'(fv_q) * sssc_pkg::ProdW'(div_eff);
			lane_h_q.rem <= '0;
			lane_h_q.quo <= clock_hz_q;
			lane_v_q.rem <= '0;
			lane_v_q.quo <= clock_hz_q;
		end
		if (cmd.div_step) begin
			lane_h_q <= lane_step(lane_h_q, prod_h_q);
			lane_v_q <= lane_step(lane_v_q, prod_v_q);
		end
		if (cmd.out_load) begin
			out_q.run_h      <= (fh_q != '0);
			out_q.period_h   <= (fh_q != '0) ? per_h : '0;
			out_q.compare_h  <= (fh_q != '0) ? per_h[sssc_pkg::PeriodW-1:1] : '0;
			out_q.dir_h_out  <= !dir_h_q;
			out_q.run_v      <= (fv_q != '0);
			out_q.period_v   <= (fv_q != '0) ? per_v : '0;
			out_q.compare_v  <= (fv_q != '0) ? per_v[sssc_pkg::PeriodW-1:1] : '0;
			out_q.dir_v_out  <= dir_v_q;
			out_q.fire_pulse <= in_q.fire_request;
		end
	end

endmodule

// ===== sv/stepper_speed_slew_controller.sv =====
// ----------------------------------------------------------------------------
// stepper_speed_slew_controller
// Joystick command to step timer settings for a two-axis stepper mount.
// ----------------------------------------------------------------------------
//  channel  | signals                        | moves
//  ---------+--------------------------------+------------------------------
//  in       | in_valid, in_stall, in_data    | one joystick command
//  out      | out_valid, out_stall, out_data | timer settings for both axes
//  cfg      | cfg_we, cfg_index, cfg_data    | one settings register write
//
//  A command runs through the scale, slew, multiply and divide steps before
//  its result is loaded, and the next command is taken only after that load.
//  The two divider lanes produce one quotient bit a cycle over the 28-bit
//  timer clock. Reset loads the default settings and clears
//  the axis state. A stalled result holds in the output register; the block
//  finishes its work and waits there before loading the next result.
// ----------------------------------------------------------------------------
module stepper_speed_slew_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  sssc_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output sssc_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [sssc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [sssc_pkg::CfgDataW-1:0]   cfg_data
);

	sssc_pkg::ctrl_cmd_t    cmd;
	sssc_pkg::ctrl_status_t status;

	sssc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	sssc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

// ===== tb/sv/stepper_speed_slew_controller_tb.sv =====
// ----------------------------------------------------------------------------
// stepper_speed_slew_controller_tb
// Drives joystick commands into the slew controller under several timer and
// slew settings, predicts the timer settings of both axes in a scoreboard and
// compares every result field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module stepper_speed_slew_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit  = 1000000;
	localparam int          DrainCycles = 64;
	localparam int          HoldCycles  = 400;
	localparam int          PhaseCount  = 8;
	localparam int          PhaseCmds   = 220;
	localparam int          DirectedCmds = 24;

	typedef struct {
		logic [sssc_pkg::ClkW-1:0]  clock_hz;
		logic [sssc_pkg::DivW-1:0]  divider;
		logic [sssc_pkg::FreqW-1:0] full_h;
		logic [sssc_pkg::FreqW-1:0] full_v;
		logic [sssc_pkg::FreqW-1:0] jump;
		logic [sssc_pkg::FreqW-1:0] ramp;
		logic [sssc_pkg::FreqW-1:0] rev_thr;
	} timer_settings_t;

	class slew_scoreboard;
		bit [31:0] clock_hz, divider, full_h, full_v, jump, ramp, rev_thr;
		bit        dir_v, dir_h, rev_pending;
		bit [15:0] last_fh;
		sssc_pkg::out_item_t expected_settings[$];
		int        mismatches;
		int        results_seen;

		function new();
			clock_hz    = 32'(sssc_pkg::RstClockHz);
			divider     = 32'(sssc_pkg::RstDivider);
			full_h      = 32'(sssc_pkg::RstFullH);
			full_v      = 32'(sssc_pkg::RstFullV);
			jump        = 32'(sssc_pkg::RstJump);
			ramp        = 32'(sssc_pkg::RstRamp);
			rev_thr     = 32'(sssc_pkg::RstRevThr);
			dir_v       = 1'b0;
			dir_h       = 1'b0;
			rev_pending = 1'b0;
			last_fh     = '0;
			mismatches  = 0;
			results_seen = 0;
		endfunction

		function void write_reg(sssc_pkg::cfg_reg_t idx,
				logic [sssc_pkg::CfgDataW-1:0] value);
			case (idx)
				sssc_pkg::CFG_CLOCK_HZ:   clock_hz = 32'(value);
				sssc_pkg::CFG_DIVIDER:    divider  = 32'(value[sssc_pkg::DivW-1:0]);
				sssc_pkg::CFG_FULL_H:     full_h   = 32'(value[sssc_pkg::FreqW-1:0]);
				sssc_pkg::CFG_FULL_V:     full_v   = 32'(value[sssc_pkg::FreqW-1:0]);
				sssc_pkg::CFG_JUMP_LIMIT: jump     = 32'(value[sssc_pkg::FreqW-1:0]);
				sssc_pkg::CFG_RAMP_STEP:  ramp     = 32'(value[sssc_pkg::FreqW-1:0]);
				sssc_pkg::CFG_REV_THR:    rev_thr  = 32'(value[sssc_pkg::FreqW-1:0]);
				default: ;
			endcase
		endfunction

		function void axis_timer(bit [31:0] freq,
				output logic [sssc_pkg::PeriodW-1:0] period,
				output logic [sssc_pkg::CompareW-1:0] cmp, output logic run);
			longint unsigned div_eff, quo, per;
			if (freq == 0) begin
				period = '0;
				cmp    = '0;
				run    = 1'b0;
			end else begin
				div_eff = (divider == 0) ? 64'd1 : 64'(divider);
				quo = 64'(clock_hz) / (64'(freq) * div_eff);
				per = (quo == 0) ? 64'd0 : quo - 64'd1;
				if (per > 64'(sssc_pkg::PeriodMax))
					per = 64'(sssc_pkg::PeriodMax);
				period = per[sssc_pkg::PeriodW-1:0];
				cmp    = per[sssc_pkg::PeriodW-1:1];
				run    = 1'b1;
			end
		endfunction

		function sssc_pkg::out_item_t predict_settings(sssc_pkg::in_item_t c);
			int        sx, sy;
			bit [31:0] ax, ay, fh, fv, last;
			sssc_pkg::out_item_t r;
			sx = {{24{c.joy_x[7]}}, c.joy_x};
			sy = {{24{c.joy_y[7]}}, c.joy_y};
			ax = (sx < 0) ? -sx : sx;
			ay = (sy < 0) ? -sy : sy;

			if (dir_v && sy < 0)
				dir_v = 1'b0;
			else if (!dir_v && sy > 0)
				dir_v = 1'b1;
			if ((dir_h && sx < 0) || (!dir_h && sx > 0))
				rev_pending = 1'b1;

			fv = ay * full_v / 128;
			fh = ax * full_h / 128;
			last = 32'(last_fh);
			if (rev_pending) begin
				if (fh + last >= rev_thr) begin
					// decelerate first, flip only once the last speed is below one step
					if (last < ramp) begin
						dir_h = ~dir_h;
						rev_pending = 1'b0;
						fh = ramp - last;
					end else begin
						fh = last - ramp;
					end
				end else begin
					dir_h = ~dir_h;
					rev_pending = 1'b0;
				end
			end else if (fh >= last + jump) begin
				fh = last + ramp;
			end else if (last >= jump && fh <= last - jump) begin
				// 32-bit wrap here saturates below like the rest
				fh = last - ramp;
			end
			if (fh > 32'hFFFF)
				fh = 32'hFFFF;
			last_fh = fh[15:0];

			axis_timer(fh, r.period_h, r.compare_h, r.run_h);
			r.dir_h_out = ~dir_h;
			axis_timer(fv, r.period_v, r.compare_v, r.run_v);
			r.dir_v_out  = dir_v;
			r.fire_pulse = c.fire_request;
			return r;
		endfunction

		function void note_command(sssc_pkg::in_item_t c);
			expected_settings.push_back(predict_settings(c));
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
			end
		endfunction

		function void check_settings(sssc_pkg::out_item_t got);
			sssc_pkg::out_item_t want;
			results_seen++;
			if (expected_settings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: unexpected transaction %p", results_seen, got);
			end else begin
				want = expected_settings.pop_front();
				compare_field("period_h", want.period_h, got.period_h);
				compare_field("compare_h", want.compare_h, got.compare_h);
				compare_field("run_h", want.run_h, got.run_h);
				compare_field("dir_h_out", want.dir_h_out, got.dir_h_out);
				compare_field("period_v", want.period_v, got.period_v);
				compare_field("compare_v", want.compare_v, got.compare_v);
				compare_field("run_v", want.run_v, got.run_v);
				compare_field("dir_v_out", want.dir_v_out, got.dir_v_out);
				compare_field("fire_pulse", want.fire_pulse, got.fire_pulse);
			end
		endfunction

		function int pending();
			return expected_settings.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	sssc_pkg::in_item_t            in_data = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	sssc_pkg::out_item_t           out_data;
	logic                          cfg_we = 1'b0;
	logic [sssc_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [sssc_pkg::CfgDataW-1:0] cfg_data = '0;

	slew_scoreboard sb;
	bit             hold_request = 1'b0;
	int             burst_left = 0;
	int unsigned    cycle_count = 0;

	stepper_speed_slew_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("stepper_speed_slew_controller_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_settings(out_data);
	end

	// receiver: short stalls, quiet stretches, and one long hold on request
	initial begin : receiver
		int run_len, stall_len, pick;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			run_len = (pick < 5) ? $urandom_range(100, 300) : $urandom_range(1, 12);
			out_stall <= 1'b0;
			repeat (run_len) @(posedge clk);
			pick = $urandom_range(0, 99);
			if (pick < 50)
				stall_len = 0;
			else if (pick < 92)
				stall_len = $urandom_range(1, 3);
			else
				stall_len = $urandom_range(10, 40);
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	function int gap_len();
		int pick;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3)
			burst_left = $urandom_range(20, 60);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function sssc_pkg::in_item_t make_command(int x, int y, bit fire);
		sssc_pkg::in_item_t c;
		c.joy_x = x[7:0];
		c.joy_y = y[7:0];
		c.fire_request = fire;
		return c;
	endfunction

	// sweeps through zero, sign flips and jumps keep the slew logic busy
	function int next_x(int prev);
		int pick, v;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			v = prev + int'($urandom_range(0, 16)) - 8;
		else if (pick < 65)
			v = -prev;
		else if (pick < 75)
			v = 0;
		else if (pick < 85)
			v = $urandom_range(0, 1) ? 127 : -128;
		else
			v = int'($urandom_range(0, 255)) - 128;
		if (v > 127)
			v = 127;
		if (v < -128)
			v = -128;
		return v;
	endfunction

	function timer_settings_t settings_for(int phase);
		timer_settings_t s;
		case (phase)
			0: s = '{sssc_pkg::RstClockHz, sssc_pkg::RstDivider, sssc_pkg::RstFullH,
				sssc_pkg::RstFullV, sssc_pkg::RstJump, sssc_pkg::RstRamp,
				sssc_pkg::RstRevThr};
			// slowest timers: long periods saturate
			1: s = '{sssc_pkg::ClkW'(200000000), sssc_pkg::DivW'(1), 16'hFFFF, 16'd1,
				16'hFFFF, 16'hFFFF, 16'hFFFF};
			// fastest request against the slowest clock: periods underflow
			2: s = '{sssc_pkg::ClkW'(1000000), sssc_pkg::DivW'(65536), 16'hFFFF, 16'hFFFF,
				16'd1, 16'd1, 16'd0};
			// divider of zero, ramp up saturates
			3: s = '{{sssc_pkg::ClkW{1'b1}}, sssc_pkg::DivW'(0), 16'hFFFF, 16'hFFFF,
				16'd1, 16'hFFFF, 16'hFFFF};
			default: begin
				s.clock_hz = ($urandom_range(0, 3) == 0) ? sssc_pkg::ClkW'($urandom)
					: sssc_pkg::ClkW'($urandom_range(1000000, 200000000));
				s.divider  = ($urandom_range(0, 3) == 0)
					? sssc_pkg::DivW'($urandom_range(1, 65536))
					: sssc_pkg::DivW'($urandom_range(1, 200));
				s.full_h   = sssc_pkg::FreqW'($urandom_range(1, 65535));
				s.full_v   = sssc_pkg::FreqW'($urandom_range(1, 65535));
				s.jump     = sssc_pkg::FreqW'($urandom_range(1, 4000));
				s.ramp     = sssc_pkg::FreqW'($urandom_range(1, 2000));
				s.rev_thr  = ($urandom_range(0, 1) == 0)
					? sssc_pkg::FreqW'($urandom_range(0, 65535))
					: sssc_pkg::FreqW'($urandom_range(0, 3000));
			end
		endcase
		return s;
	endfunction

	task automatic write_reg(sssc_pkg::cfg_reg_t idx, logic [sssc_pkg::CfgDataW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic apply_settings(timer_settings_t s);
		write_reg(sssc_pkg::CFG_CLOCK_HZ, s.clock_hz);
		write_reg(sssc_pkg::CFG_DIVIDER, sssc_pkg::CfgDataW'(s.divider));
		write_reg(sssc_pkg::CFG_FULL_H, sssc_pkg::CfgDataW'(s.full_h));
		write_reg(sssc_pkg::CFG_FULL_V, sssc_pkg::CfgDataW'(s.full_v));
		write_reg(sssc_pkg::CFG_JUMP_LIMIT, sssc_pkg::CfgDataW'(s.jump));
		write_reg(sssc_pkg::CFG_RAMP_STEP, sssc_pkg::CfgDataW'(s.ramp));
		write_reg(sssc_pkg::CFG_REV_THR, sssc_pkg::CfgDataW'(s.rev_thr));
		cfg_we <= 1'b0;
	endtask

	task automatic send_command(sssc_pkg::in_item_t c);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_command(c);
	endtask

	task automatic wait_idle();
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int dir_x [DirectedCmds] = '{0, 127, 127, 127, -128, -128, -128, -128, 0, 127, 127, 127,
			127, 127, 127, 0, 0, 1, -1, 1, 64, -64, -128, 127};
		int dir_y [DirectedCmds] = '{0, 127, -128, 1, -1, 0, 127, -128, 0, 5, -5, 64,
			-64, 0, 1, -1, 127, -128, 0, 3, -3, 100, -100, 0};
		int edge_x [4] = '{127, -128, 0, 1};
		int edge_y [4] = '{127, -128, 0, -1};
		int x, y;

		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: stop, reversal ramps, jump limiting both ways
		for (int i = 0; i < DirectedCmds; i++)
			send_command(make_command(dir_x[i], dir_y[i], (i % 3) == 1));

		x = 0;
		for (int phase = 0; phase < PhaseCount; phase++) begin
			in_valid <= 1'b0;
			wait_idle();
			apply_settings(settings_for(phase));
			for (int i = 0; i < PhaseCmds; i++) begin
				if (phase == 1 && i == 30)
					hold_request = 1'b1;
				if (i < 4) begin
					x = edge_x[i];
					y = edge_y[i];
				end else begin
					x = next_x(x);
					y = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(0, 255)) - 128;
				end
				send_command(make_command(x, y, 1'($urandom_range(0, 1))));
			end
		end
		in_valid <= 1'b0;

		wait_idle();
		repeat (DrainCycles) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("stepper_speed_slew_controller_tb passed");
		else
			$display("stepper_speed_slew_controller_tb failed");
		$finish;
	end

endmodule
